// ===== hdl/fixed_block_free_list_allocator_unit_assert.svh =====
// Assertion macros shared by the free-list allocator RTL
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define FBFLA_AST_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define FBFLA_AST_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/fbfla_pkg.sv =====
// Shared constants, codes and control/status types of the free-list allocator
`timescale 1ns / 1ps
package fbfla_pkg;

	// default pool depth
	localparam int MAX_BLOCKS_DEF = 256;

	// payload widths
	localparam int IDX_W   = 8;
	localparam int OFS_W   = 24;
	localparam int BSIZE_W = 16;
	localparam int BCNT_W  = 9;

	// configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd1;

	// register reset values
	localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RST  = 16'd16;
	localparam logic [BCNT_W-1:0]  BLOCK_COUNT_RST = 9'd256;

	// input command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic sweep_step;    // write one link of the relink pass
		logic sweep_finish;  // relink pass done, set the head
		logic free_cmd;      // free beat accepted
		logic alloc_read;    // allocate beat accepted, read link of head
		logic alloc_finish;  // load result register, advance head
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic sweep_done;    // all links of the pool written
		logic out_free;      // result register can take a new result
		logic relink;        // block_count written this cycle
	} dp_sts_t;

endpackage

// ===== hdl/fbfla_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module fbfla_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/fbfla_ctrl.sv =====
// Controller state machine of the free-list allocator
`timescale 1ns / 1ps
module fbfla_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              command,
	input  fbfla_pkg::dp_sts_t sts,
	output logic              in_stall,
	output fbfla_pkg::dp_cmd_t cmd
);
	import fbfla_pkg::*;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_ALLOC
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// command decode
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_SWEEP: begin
				cmd.sweep_step   = !sts.sweep_done;
				cmd.sweep_finish = sts.sweep_done;
			end
			ST_IDLE: begin
				cmd.free_cmd   = accept && (command == CMD_FREE);
				cmd.alloc_read = accept && (command == CMD_ALLOC);
			end
			ST_ALLOC: begin
				cmd.alloc_finish = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// state register; a block_count write restarts the relink pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else if (sts.relink) begin
			state_q <= ST_SWEEP;
		end else begin
			unique case (state_q)
				ST_SWEEP: begin
					if (sts.sweep_done) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept && (command == CMD_ALLOC)) state_q <= ST_ALLOC;
				end
				ST_ALLOC: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_SWEEP;
				end
			endcase
		end
	end

endmodule

// ===== hdl/fbfla_dp.sv =====
// Datapath of the free-list allocator: registers, link RAM, head, result
`timescale 1ns / 1ps
module fbfla_dp #(
	parameter int MAX_BLOCKS = fbfla_pkg::MAX_BLOCKS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fbfla_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fbfla_pkg::CFG_DAT_W-1:0]   cfg_data,
	// input payload
	input  logic [fbfla_pkg::IDX_W-1:0]       free_index,
	input  logic                              free_null,
	// result
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              granted,
	output logic [fbfla_pkg::IDX_W-1:0]       block_index,
	output logic [fbfla_pkg::OFS_W-1:0]       block_offset,
	// control
	input  fbfla_pkg::dp_cmd_t                cmd,
	output fbfla_pkg::dp_sts_t                sts
);
	import fbfla_pkg::*;

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int LW = IW + 1;
	localparam int PW = IW + BSIZE_W;
	localparam logic [LW-1:0] LINK_NULL = LW'(MAX_BLOCKS);

	logic [BSIZE_W-1:0] block_size_q;
	logic [BCNT_W-1:0]  block_count_q;
	logic [LW-1:0]      head_q;
	logic [LW-1:0]      cnt_q;
	logic [LW-1:0]      pool_n;
	logic [LW-1:0]      cnt_nxt;
	logic               cfg_wr;
	logic               relink;
	logic               head_null;
	logic               push_ok;
	logic               out_valid_q;
	logic               granted_q;
	logic [IDX_W-1:0]   index_q;
	logic [OFS_W-1:0]   offset_q;
	logic [PW-1:0]      product;
	logic               ram_we;
	logic [IW-1:0]      ram_waddr;
	logic [LW-1:0]      ram_wdata;
	logic [LW-1:0]      ram_rdata;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign relink    = cfg_wr && (cfg_index == REG_BLOCK_COUNT);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q  <= BLOCK_SIZE_RST;
			block_count_q <= BLOCK_COUNT_RST;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_BLOCK_SIZE:  block_size_q  <= cfg_data;
				REG_BLOCK_COUNT: block_count_q <= cfg_data[BCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// pool size, capped at the link RAM depth
	assign pool_n  = (int'(block_count_q) > MAX_BLOCKS) ? LINK_NULL : LW'(block_count_q);
	assign cnt_nxt = cnt_q + LW'(1);

	// relink pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (relink) begin
			cnt_q <= '0;
		end else if (cmd.sweep_step) begin
			cnt_q <= cnt_nxt;
		end
	end

	assign head_null = (head_q == LINK_NULL);
	assign push_ok   = cmd.free_cmd && !free_null && (int'(free_index) < MAX_BLOCKS);

	// link RAM write: relink pass or a pushed block
	always_comb begin
		ram_we    = cmd.sweep_step || push_ok;
		ram_waddr = cnt_q[IW-1:0];
		ram_wdata = (cnt_nxt == pool_n) ? LINK_NULL : cnt_nxt;
		if (push_ok) begin
			ram_waddr = IW'(free_index);
			ram_wdata = head_q;
		end
	end

	fbfla_ram #(
		.WIDTH (LW),
		.DEPTH (MAX_BLOCKS)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.alloc_read),
		.raddr (head_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	// head of the free list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else if (cmd.sweep_finish) begin
			head_q <= (pool_n == '0) ? LINK_NULL : '0;
		end else if (push_ok) begin
			head_q <= LW'(free_index);
		end else if (cmd.alloc_finish && !head_null) begin
			head_q <= ram_rdata;
		end
	end

	// byte offset of the head block
	assign product = PW'(head_q[IW-1:0]) * PW'(block_size_q);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.alloc_finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.alloc_finish) begin
			granted_q <= !head_null;
			index_q   <= head_null ? '0 : IDX_W'(head_q);
			offset_q  <= head_null ? '0 : OFS_W'(product);
		end
	end

	assign out_valid    = out_valid_q;
	assign granted      = granted_q;
	assign block_index  = index_q;
	assign block_offset = offset_q;

	assign sts.sweep_done = (cnt_q == pool_n);
	assign sts.out_free   = !out_valid_q || !out_stall;
	assign sts.relink     = relink;

endmodule

// ===== hdl/fixed_block_free_list_allocator_unit.sv =====
// Top level of the fixed-size block free-list allocator
`timescale 1ns / 1ps
// Usage:
//  Input channel (in_valid/in_stall): command 0 allocates a block, command 1
//  frees free_index (ignored when free_null is set or free_index is not below
//  MAX_BLOCKS). Output channel (out_valid/out_stall): one beat per allocate
//  with granted, block_index and block_offset = index * block_size; granted
//  is 0 with zero fields when the pool is exhausted. Frees give no beat.
//  Config channel (cfg_valid/cfg_ready, always ready): index 0 block_size,
//  index 1 block_count; other indexes are ignored.
//  Timing: a free is taken in the idle state; an allocate also passes the
//  allocate state, set by the registered read of the next link of the head
//  from the link RAM, and loads the output register once that register drains.
//  Reset and every block_count write start a relink pass that writes one
//  link per cycle; in_stall is high during the pass and config writes are
//  still taken. A stalled result holds in the output register; the block
//  keeps taking frees meanwhile unless an allocate is pending, and it
//  finishes a pending allocate once the register drains.
module fixed_block_free_list_allocator_unit #(
	parameter int MAX_BLOCKS = fbfla_pkg::MAX_BLOCKS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            command,
	input  logic [fbfla_pkg::IDX_W-1:0]     free_index,
	input  logic                            free_null,
	// output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            granted,
	output logic [fbfla_pkg::IDX_W-1:0]     block_index,
	output logic [fbfla_pkg::OFS_W-1:0]     block_offset,
	// configuration channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fbfla_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fbfla_pkg::CFG_DAT_W-1:0] cfg_data
);
	import fbfla_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    alloc_beat;
	logic    free_beat;

	fbfla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	fbfla_dp #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.free_index   (free_index),
		.free_null    (free_null),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.granted      (granted),
		.block_index  (block_index),
		.block_offset (block_offset),
		.cmd          (cmd),
		.sts          (sts)
	);

	// accepted beats, for the checks below
	assign alloc_beat = in_valid && !in_stall && (command == CMD_ALLOC);
	assign free_beat  = in_valid && !in_stall && (command == CMD_FREE);

`include "fixed_block_free_list_allocator_unit_assert.svh"

	`FBFLA_AST_NXT(a_alloc_result, alloc_beat && !out_valid && !cfg_valid, ##1 out_valid, "allocate gave no result in two cycles")
	`FBFLA_AST_NXT(a_free_silent, free_beat && !out_valid, !out_valid, "free produced a result")
	`FBFLA_AST_IMP(a_one_writer, cmd.sweep_step, !cmd.free_cmd && !cmd.alloc_read, "relink pass overlaps an item")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of the free-list allocator: directed table, then random traffic
`timescale 1ns / 1ps
module tb_top;
	import fbfla_pkg::*;

	localparam logic [BCNT_W-1:0] LINK_END = BCNT_W'(MAX_BLOCKS_DEF);

	// config indexes that the block has no register for
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 150;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DIR_ROWS      = 28;

	typedef struct packed {
		logic             granted;
		logic [IDX_W-1:0] index;
		logic [OFS_W-1:0] offset;
	} grant_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic                 cmd;
		logic [IDX_W-1:0]     idx;
		logic                 nul;
		logic [CFG_IDX_W-1:0] sel;
		logic [CFG_DAT_W-1:0] data;
		logic                 typed;
		grant_t               want;
	} dir_row_t;

	// directed rows; typed rows carry their grant, the rest go through the pool model
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		'{ROW_ITEM, CMD_ALLOC, 8'h00, 1'b0, REG_BLOCK_SIZE, 16'h0, 1'b1, '{1'b1, 8'd0, 24'd0}},
		'{ROW_ITEM, CMD_ALLOC, 8'hFF, 1'b1, REG_BLOCK_SIZE, 16'h0, 1'b1, '{1'b1, 8'd1, 24'd16}},
		'{ROW_ITEM, CMD_FREE, 8'h00, 1'b1, REG_BLOCK_SIZE, 16'h0, 1'b0, '0},
		'{ROW_ITEM, CMD_ALLOC, 8'h00, 1'b0, REG_BLOCK_SIZE, 16'h0, 1'b1, '{1'b1, 8'd2, 24'd32}},
		'{ROW_ITEM, CMD_FREE, 8'h01, 1'b0, REG_BLOCK_SIZE, 16'h0, 1'b0, '0},
		'{ROW_ITEM, CMD_FREE, 8'hFF, 1'b0, REG_BLOCK_SIZE, 16'h0, 1'b0, '0},
		'{ROW_ITEM, CMD_ALLOC, 8'h00, 1'b0, REG_BLOCK_SIZE, 16'h0, 1'b1,
			'{1'b1, 8'd255, 24'd4080}},
		'{ROW_ITEM, CMD_ALLOC, 8'h5A, 1'b0, REG_BLOCK_SIZE, 16'h0, 1'b0, '0},
		'{ROW_CFG, CMD_ALLOC, 8'h00, 1'b0, REG_SPARE_A, 16'hFFFF, 1'b0, '0},
		'{ROW_CFG, CMD_ALLOC, 8'h00, 1'b0, REG_SPARE_B, 16'h0000, 1'b0, '0},
		'{ROW_ITEM, CMD_ALLOC, 8'h00, 1'b0, REG_BLOCK_SIZE, 16'h0, 1'b0, '0},
		'{ROW_CFG, CMD_ALLOC, 8'h00, 1'b0, REG_BLOCK_COUNT, 16'd0, 1'b0, '0},
		'{ROW_ITEM, CMD_ALLOC, 8'h00, 1'b0, REG_BLOCK_SIZE, 16'h0, 1'b1, '{1'b0, 8'd0, 24'd0}},
		'{ROW_ITEM, CMD_FREE, 8'h07, 1'b0, REG_BLOCK_SIZE, 16'h0, 1'b0, '0},
		'{ROW_ITEM, CMD_ALLOC, 8'h00, 1'b0, REG_BLOCK_SIZE, 16'h0, 1'b1,
			'{1'b1, 8'd7, 24'd112}},
		'{ROW_ITEM, CMD_ALLOC, 8'h00, 1'b0, REG_BLOCK_SIZE, 16'h0, 1'b1, '{1'b0, 8'd0, 24'd0}},
		'{ROW_CFG, CMD_ALLOC, 8'h00, 1'b0, REG_BLOCK_COUNT, 16'd1, 1'b0, '0},
		'{ROW_ITEM, CMD_ALLOC, 8'h00, 1'b0, REG_BLOCK_SIZE, 16'h0, 1'b1, '{1'b1, 8'd0, 24'd0}},
		'{ROW_ITEM, CMD_ALLOC, 8'h00, 1'b0, REG_BLOCK_SIZE, 16'h0, 1'b1, '{1'b0, 8'd0, 24'd0}},
		'{ROW_CFG, CMD_ALLOC, 8'h00, 1'b0, REG_BLOCK_SIZE, 16'hFFFF, 1'b0, '0},
		'{ROW_CFG, CMD_ALLOC, 8'h00, 1'b0, REG_BLOCK_COUNT, 16'h01FF, 1'b0, '0},
		'{ROW_ITEM, CMD_FREE, 8'hFF, 1'b0, REG_BLOCK_SIZE, 16'h0, 1'b0, '0},
		'{ROW_ITEM, CMD_ALLOC, 8'h00, 1'b0, REG_BLOCK_SIZE, 16'h0, 1'b1,
			'{1'b1, 8'd255, 24'd16711425}},
		'{ROW_ITEM, CMD_ALLOC, 8'h00, 1'b0, REG_BLOCK_SIZE, 16'h0, 1'b1, '{1'b1, 8'd0, 24'd0}},
		'{ROW_ITEM, CMD_ALLOC, 8'h00, 1'b0, REG_BLOCK_SIZE, 16'h0, 1'b0, '0},
		'{ROW_CFG, CMD_ALLOC, 8'h00, 1'b0, REG_BLOCK_SIZE, 16'd1, 1'b0, '0},
		'{ROW_ITEM, CMD_FREE, 8'h80, 1'b0, REG_BLOCK_SIZE, 16'h0, 1'b0, '0},
		'{ROW_ITEM, CMD_ALLOC, 8'h00, 1'b0, REG_BLOCK_SIZE, 16'h0, 1'b1,
			'{1'b1, 8'd128, 24'd128}}
	};

	// per-phase register settings; the last phase draws its own
	localparam logic [BCNT_W-1:0] PHASE_COUNTS [PHASES] = '{
		9'd3, 9'd0, 9'd17, 9'd511, 9'd1, 9'd64, 9'd256, 9'd2, 9'd300, 9'd5
	};
	localparam logic [BSIZE_W-1:0] PHASE_SIZES [PHASES] = '{
		16'd16, 16'd65535, 16'd7, 16'd1, 16'd4096, 16'd255, 16'd65535, 16'd40000,
		16'd1000, 16'd3
	};

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_stall;
	logic                 command      = CMD_ALLOC;
	logic [IDX_W-1:0]     free_index   = '0;
	logic                 free_null    = 1'b0;
	logic                 out_valid;
	logic                 out_stall    = 1'b0;
	logic                 granted;
	logic [IDX_W-1:0]     block_index;
	logic [OFS_W-1:0]     block_offset;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = REG_BLOCK_SIZE;
	logic [CFG_DAT_W-1:0] cfg_data     = '0;

	// pool model: registers, head and link store
	logic [BSIZE_W-1:0] pool_bsize;
	logic [BCNT_W-1:0]  pool_bcount;
	logic [BCNT_W-1:0]  pool_head;
	logic [BCNT_W-1:0]  pool_links [MAX_BLOCKS_DEF];

	grant_t           pending_grants [$];
	logic [IDX_W-1:0] held_blocks [$];
	int               items_sent  = 0;
	int               fail_count  = 0;
	int               cycle_count = 0;

	always #1 clk = ~clk;

	fixed_block_free_list_allocator_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.free_index   (free_index),
		.free_null    (free_null),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.granted      (granted),
		.block_index  (block_index),
		.block_offset (block_offset),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// link blocks in index order; a count past the pool depth saturates
	function automatic void relink_pool();
		int n;
		n = (int'(pool_bcount) > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : int'(pool_bcount);
		for (int i = 0; i < MAX_BLOCKS_DEF; i++)
			pool_links[i] = LINK_END;
		for (int i = 0; i + 1 < n; i++)
			pool_links[i] = BCNT_W'(i + 1);
		pool_head = (n == 0) ? LINK_END : '0;
		held_blocks.delete();
	endfunction

	function automatic void model_reg_write(input logic [CFG_IDX_W-1:0] sel,
			input logic [CFG_DAT_W-1:0] data);
		case (sel)
			REG_BLOCK_SIZE: pool_bsize = data[BSIZE_W-1:0];
			REG_BLOCK_COUNT: begin
				pool_bcount = data[BCNT_W-1:0];
				relink_pool();
			end
			default: ;
		endcase
	endfunction

	// returns 1 when the item yields a grant beat
	function automatic bit model_item(input logic cmd, input logic [IDX_W-1:0] idx,
			input logic nul, output grant_t res);
		logic [39:0] prod;
		res = '0;
		if (cmd == CMD_FREE) begin
			// every 8-bit index has a link entry, so only a null free is dropped
			if (!nul) begin
				pool_links[idx] = pool_head;
				pool_head = {1'b0, idx};
			end
			return 1'b0;
		end
		if (pool_head >= LINK_END)
			return 1'b1;
		prod = 40'(pool_head) * 40'(pool_bsize);
		res.granted = 1'b1;
		res.index   = pool_head[IDX_W-1:0];
		res.offset  = prod[OFS_W-1:0];
		pool_head   = pool_links[pool_head[IDX_W-1:0]];
		held_blocks.push_back(res.index);
		return 1'b1;
	endfunction

	// idle pattern: sender light / receiver heavy, then swapped, then none
	function automatic int send_idle_pct();
		if (items_sent < 500)
			return 23;
		else if (items_sent < 1000)
			return 74;
		return 0;
	endfunction

	function automatic int recv_idle_pct();
		if (items_sent < 500)
			return 74;
		else if (items_sent < 1000)
			return 23;
		return 0;
	endfunction

	task automatic send_item(input logic cmd, input logic [IDX_W-1:0] idx, input logic nul,
			input logic typed, input grant_t want);
		grant_t got;
		bit     has_res;
		cfg_valid <= 1'b0;
		while ($urandom_range(0, 99) < send_idle_pct()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		command    <= cmd;
		free_index <= idx;
		free_null  <= nul;
		do @(posedge clk); while (in_stall !== 1'b0);
		has_res = model_item(cmd, idx, nul, got);
		if (has_res)
			pending_grants.push_back(typed ? want : got);
		items_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] sel,
			input logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		model_reg_write(sel, data);
	endtask

	// hold off until every grant is back, then let a trailing free settle
	task automatic wait_results_done();
		in_valid  <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// allocates at alloc_pct; else mostly frees of blocks on loan, some null and stray frees
	task automatic random_item(input int alloc_pct);
		logic [IDX_W-1:0] idx;
		logic             nul;
		int               pos;
		int               pick;
		idx  = IDX_W'($urandom);
		nul  = 1'($urandom);
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < alloc_pct) begin
			send_item(CMD_ALLOC, idx, nul, 1'b0, '0);
		end else if (pick >= 80 && pick < 90) begin
			send_item(CMD_FREE, idx, 1'b1, 1'b0, '0);
		end else if (pick < 80 && held_blocks.size() != 0) begin
			pos = $urandom_range(0, held_blocks.size() - 1);
			idx = held_blocks[pos];
			held_blocks.delete(pos);
			send_item(CMD_FREE, idx, 1'b0, 1'b0, '0);
		end else begin
			send_item(CMD_FREE, idx, 1'b0, 1'b0, '0);
		end
	endtask

	task automatic check_grant();
		grant_t want;
		if (pending_grants.size() == 0) begin
			$error("unexpected beat: granted %0d block_index %0d block_offset %0d",
				granted, block_index, block_offset);
			fail_count++;
		end else begin
			want = pending_grants.pop_front();
			if (granted !== want.granted) begin
				$error("granted: expected %0d, got %0d", want.granted, granted);
				fail_count++;
			end
			if (block_index !== want.index) begin
				$error("block_index: expected %0d, got %0d", want.index, block_index);
				fail_count++;
			end
			if (block_offset !== want.offset) begin
				$error("block_offset: expected %0d, got %0d", want.offset, block_offset);
				fail_count++;
			end
		end
	endtask

	// result side: check at the edge, pick the next stall
	initial begin
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0)
				check_grant();
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct());
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[fixed_block_free_list_allocator_unit] ERROR");
			$finish;
		end
	end

	// stimulus
	initial begin
		dir_row_t           row;
		logic [BCNT_W-1:0]  count_val;
		logic [BSIZE_W-1:0] size_val;
		int                 alloc_pct;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		pool_bsize  = BLOCK_SIZE_RST;
		pool_bcount = BLOCK_COUNT_RST;
		relink_pool();

		// directed table
		for (int r = 0; r < DIR_ROWS; r++) begin
			row = DIR_TABLE[r];
			if (row.kind == ROW_CFG) begin
				wait_results_done();
				write_reg(row.sel, row.data);
			end else begin
				send_item(row.cmd, row.idx, row.nul, row.typed, row.want);
			end
		end

		// random phases, each under its own register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			count_val = PHASE_COUNTS[ph];
			size_val  = PHASE_SIZES[ph];
			if (ph == PHASES - 1) begin
				count_val = BCNT_W'($urandom_range(1, 256));
				size_val  = BSIZE_W'($urandom_range(1, 65535));
			end
			wait_results_done();
			write_reg(REG_BLOCK_SIZE, size_val);
			if (ph % 3 == 1)
				write_reg((ph % 2 == 0) ? REG_SPARE_A : REG_SPARE_B, CFG_DAT_W'($urandom));
			write_reg(REG_BLOCK_COUNT, CFG_DAT_W'(count_val));
			alloc_pct = $urandom_range(35, 75);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// drain halfway through the phase
				if (k == PHASE_ITEMS / 2)
					wait_results_done();
				random_item(alloc_pct);
			end
		end

		wait_results_done();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[fixed_block_free_list_allocator_unit] OK");
		else
			$display("[fixed_block_free_list_allocator_unit] ERROR");
		$finish;
	end

endmodule
